@@ rtl/core/slos_pkg.sv @@
// slos_pkg: shared types and constants of the line-of-sight block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package slos_pkg;

   localparam int COORD_W = 14;
   localparam int CELLF_W = 6;
   localparam int TOL_W   = 4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_PT_START,
      ST_WALK,
      ST_SIDE_A,
      ST_SIDE_B,
      ST_NEIGH,
      ST_PT_END,
      ST_FINISH
   } slos_state_type;

   typedef struct packed {
      logic load_x;
      logic load_y;
      logic step_x;
      logic step_y;
   } cross_cmd_type;

   typedef struct packed {
      logic x_first;
      logic y_first;
   } cross_stat_type;

endpackage

@@ rtl/core/slos_req_if.sv @@
// slos_req_if: request channel (map write or query word) with valid/ready.
// Depends on slos_pkg for field widths.
`timescale 1ns / 1ps

interface slos_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [slos_pkg::CELLF_W-1:0] cell_x;
   logic [slos_pkg::CELLF_W-1:0] cell_y;
   logic                         blocked;
   logic [slos_pkg::COORD_W-1:0] start_x;
   logic [slos_pkg::COORD_W-1:0] start_y;
   logic [slos_pkg::COORD_W-1:0] end_x;
   logic [slos_pkg::COORD_W-1:0] end_y;

   modport source (output valid, operation, cell_x, cell_y, blocked,
                   start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, operation, cell_x, cell_y, blocked,
                   start_x, start_y, end_x, end_y, output ready);
endinterface

@@ rtl/core/slos_rsp_if.sv @@
// slos_rsp_if: response channel carrying one line_clear word per query.
// No dependencies.
`timescale 1ns / 1ps

interface slos_rsp_if;
   logic valid;
   logic ready;
   logic line_clear;

   modport source (output valid, line_clear, input ready);
   modport sink   (input valid, line_clear, output ready);
endinterface

@@ rtl/core/slos_map_mem.sv @@
// slos_map_mem: single-port obstacle bitmap, one bit per cell, registered read.
// Standalone; addressed as {row, column}.
`timescale 1ns / 1ps

module slos_map_mem #(
   parameter int GRID_BITS = 6,
   localparam int ADDR_W = 2 * GRID_BITS,
   localparam int DEPTH  = 1 << ADDR_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic              wr_data,
   output logic              rd_data
);

   logic map_ff [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[addr] <= wr_data;
      end
      rd_data_ff <= map_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/slos_cross_unit.sv @@
// slos_cross_unit: shared multiplier and crossing comparator of the walk.
// Loads nx*|dy| and ny*|dx|, then adds one cell step per move. Uses slos_pkg.
`timescale 1ns / 1ps

module slos_cross_unit #(
   parameter int FRAC_BITS = 8,
   localparam int N_W = ((slos_pkg::COORD_W > FRAC_BITS) ? slos_pkg::COORD_W : FRAC_BITS) + 1
) (
   input  logic                         clock,
   input  slos_pkg::cross_cmd_type      cmd,
   input  logic [N_W-1:0]               gap_x,
   input  logic [N_W-1:0]               gap_y,
   input  logic [slos_pkg::COORD_W-1:0] adx,
   input  logic [slos_pkg::COORD_W-1:0] ady,
   output slos_pkg::cross_stat_type     stat
);
   import slos_pkg::*;

   localparam int PROD_W = N_W + COORD_W;

   logic [N_W-1:0]     mul_a;
   logic [COORD_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  inc_x;
   logic [PROD_W-1:0]  inc_y;
   logic [PROD_W-1:0]  lhs_ff, lhs_in;
   logic [PROD_W-1:0]  rhs_ff, rhs_in;

   assign mul_a = cmd.load_y ? gap_y : gap_x;
   assign mul_b = cmd.load_y ? adx : ady;
   assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign inc_x = PROD_W'(ady) << FRAC_BITS;
   assign inc_y = PROD_W'(adx) << FRAC_BITS;

   always_comb begin
      lhs_in = lhs_ff;
      rhs_in = rhs_ff;
      if (cmd.load_x) begin
         lhs_in = prod;
      end else if (cmd.step_x) begin
         lhs_in = lhs_ff + inc_x;
      end
      if (cmd.load_y) begin
         rhs_in = prod;
      end else if (cmd.step_y) begin
         rhs_in = rhs_ff + inc_y;
      end
   end

   always_ff @(posedge clock) begin
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
   end

   assign stat.x_first = lhs_ff < rhs_ff;
   assign stat.y_first = rhs_ff < lhs_ff;

endmodule

@@ rtl/core/slos_seq.sv @@
// slos_seq: sequencer of the block: map clearing, writes, query setup,
// endpoint cells and supercover walk, at most one bitmap probe per cycle. Uses slos_pkg.
`timescale 1ns / 1ps

module slos_seq #(
   parameter int GRID_BITS = 6,
   parameter int FRAC_BITS = 8,
   localparam int ADDR_W = 2 * GRID_BITS,
   localparam int N_W = ((slos_pkg::COORD_W > FRAC_BITS) ? slos_pkg::COORD_W : FRAC_BITS) + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   slos_req_if.sink                     req_bus,
   input  logic [slos_pkg::TOL_W-1:0]   tol,
   input  logic                         rsp_free,
   output logic                         done,
   output logic                         line_clear,
   output logic                         mem_wr_en,
   output logic [ADDR_W-1:0]            mem_addr,
   output logic                         mem_wr_data,
   input  logic                         mem_rd_data,
   output slos_pkg::cross_cmd_type      cross_cmd,
   input  slos_pkg::cross_stat_type     cross_stat,
   output logic [N_W-1:0]               gap_x,
   output logic [N_W-1:0]               gap_y,
   output logic [slos_pkg::COORD_W-1:0] adx,
   output logic [slos_pkg::COORD_W-1:0] ady
);
   import slos_pkg::*;

   localparam int CELL_W = (FRAC_BITS >= COORD_W) ? 1 : COORD_W - FRAC_BITS;
   localparam int PW     = ((CELL_W > GRID_BITS) ? CELL_W : GRID_BITS) + 2;
   localparam int FW     = FRAC_BITS + 1;
   localparam int FX_W   = FW + COORD_W;
   localparam int CMP_W  = (FW > TOL_W) ? FW : TOL_W;
   localparam logic [FW-1:0]        ONE_LSB  = FW'(1) << FRAC_BITS;
   localparam logic signed [PW-1:0] GRID_LIM = PW'(1 << GRID_BITS);
   localparam logic signed [1:0]    OFF_NEG  = -2'sd1;
   localparam logic signed [1:0]    OFF_POS  = 2'sd1;
   localparam logic signed [1:0]    OFF_ZERO = 2'sd0;

   function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] sh;
      sh = v >> FRAC_BITS;
      cell_of = sh[CELL_W-1:0];
   endfunction

   function automatic logic [FW-1:0] frac_of(input logic [COORD_W-1:0] v);
      logic [FX_W-1:0] wide;
      logic [FX_W-1:0] mask;
      wide = FX_W'(v);
      mask = (FX_W'(1) << FRAC_BITS) - FX_W'(1);
      frac_of = FW'(wide & mask);
   endfunction

   function automatic logic on_line(input logic [COORD_W-1:0] v,
                                    input logic [TOL_W-1:0] t);
      logic [FW-1:0] f;
      logic [FW-1:0] r;
      f = frac_of(v);
      r = ONE_LSB - f;
      on_line = (CMP_W'(f) <= CMP_W'(t)) || (CMP_W'(r) <= CMP_W'(t));
   endfunction

   function automatic logic [N_W-1:0] first_gap(input logic [COORD_W-1:0] v,
                                                input logic up);
      logic [FW-1:0] f;
      f = frac_of(v);
      first_gap = up ? N_W'(ONE_LSB - f) : N_W'(f);
   endfunction

   function automatic logic signed [PW-1:0] shift_c(input logic [CELL_W-1:0] c,
                                                    input logic signed [1:0] d);
      shift_c = $signed(PW'(c)) + PW'(d);
   endfunction

   slos_state_type state_ff, state_in;
   logic [1:0]        k_ff, k_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              hit_ff, hit_in;
   logic              live_ff, live_in;

   logic [CELL_W-1:0] x_ff, x_in, y_ff, y_in, ex_ff, ex_in, ey_ff, ey_in;
   logic              sxn_ff, sxn_in, sxm_ff, sxm_in, syn_ff, syn_in, sym_ff, sym_in;
   logic              hline_ff, hline_in, vline_ff, vline_in;
   logic              lax_ff, lax_in, lay_ff, lay_in, lbx_ff, lbx_in, lby_ff, lby_in;
   logic [N_W-1:0]     gapx_ff, gapx_in, gapy_ff, gapy_in;
   logic [COORD_W-1:0] adx_ff, adx_in, ady_ff, ady_in;

   logic accept, query_go;
   logic xa, ya, mv_x, mv_y, corner;
   logic [CELL_W-1:0] nxt_x, nxt_y;

   logic [CELL_W-1:0]     base_x, base_y;
   logic signed [1:0]     off_x, off_y;
   logic                  probe_en, probe_go;
   logic signed [PW-1:0]  px, py;
   logic [GRID_BITS-1:0]  wx, wy;

   assign accept   = req_bus.valid && req_bus.ready;
   assign query_go = accept && (req_bus.operation == OP_QUERY);
   assign wx       = GRID_BITS'(req_bus.cell_x);
   assign wy       = GRID_BITS'(req_bus.cell_y);

   // step decision of the walk
   always_comb begin
      xa     = sxn_ff && (x_ff != ex_ff);
      ya     = syn_ff && (y_ff != ey_ff);
      mv_x   = xa && (!ya || !cross_stat.y_first);
      mv_y   = ya && (!xa || !cross_stat.x_first);
      corner = mv_x && mv_y;
      nxt_x  = x_ff;
      nxt_y  = y_ff;
      if (mv_x) begin
         nxt_x = sxm_ff ? x_ff - CELL_W'(1) : x_ff + CELL_W'(1);
      end
      if (mv_y) begin
         nxt_y = sym_ff ? y_ff - CELL_W'(1) : y_ff + CELL_W'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (query_go) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_PT_START;
         ST_PT_START: begin
            if (k_ff == 2'd3) begin
               state_in = (sxn_ff || syn_ff) ? ST_WALK : ST_FINISH;
            end
         end
         ST_WALK: begin
            if (!xa && !ya) begin
               state_in = ST_PT_END;
            end else if (corner) begin
               state_in = ST_SIDE_A;
            end else if (hline_ff || vline_ff) begin
               state_in = ST_NEIGH;
            end
         end
         ST_SIDE_A: state_in = ST_SIDE_B;
         ST_SIDE_B: state_in = ST_WALK;
         ST_NEIGH:  state_in = ST_WALK;
         ST_PT_END: begin
            if (k_ff == 2'd3) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs: request ready, done, probe selection, memory port, shared unit commands
   always_comb begin
      req_bus.ready = 1'b0;
      cross_cmd     = '0;
      base_x        = x_ff;
      base_y        = y_ff;
      off_x         = OFF_ZERO;
      off_y         = OFF_ZERO;
      probe_en      = 1'b0;
      done          = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_MUL_X: cross_cmd.load_x = 1'b1;
         ST_MUL_Y: cross_cmd.load_y = 1'b1;
         ST_PT_START: begin
            off_x    = k_ff[0] ? OFF_NEG : OFF_ZERO;
            off_y    = k_ff[1] ? OFF_NEG : OFF_ZERO;
            probe_en = (!k_ff[0] || lax_ff) && (!k_ff[1] || lay_ff);
         end
         ST_PT_END: begin
            base_x   = ex_ff;
            base_y   = ey_ff;
            off_x    = k_ff[0] ? OFF_NEG : OFF_ZERO;
            off_y    = k_ff[1] ? OFF_NEG : OFF_ZERO;
            probe_en = (!k_ff[0] || lbx_ff) && (!k_ff[1] || lby_ff);
         end
         ST_WALK: begin
            base_x           = nxt_x;
            base_y           = nxt_y;
            probe_en         = xa || ya;
            cross_cmd.step_x = mv_x;
            cross_cmd.step_y = mv_y;
         end
         ST_SIDE_A: begin
            off_y    = sym_ff ? OFF_POS : OFF_NEG;
            probe_en = 1'b1;
         end
         ST_SIDE_B: begin
            off_x    = sxm_ff ? OFF_POS : OFF_NEG;
            probe_en = 1'b1;
         end
         ST_NEIGH: begin
            off_x    = hline_ff ? OFF_ZERO : OFF_NEG;
            off_y    = hline_ff ? OFF_NEG : OFF_ZERO;
            probe_en = 1'b1;
         end
         ST_FINISH: done = rsp_free;
         default: ;
      endcase

      px       = shift_c(base_x, off_x);
      py       = shift_c(base_y, off_y);
      probe_go = probe_en && !px[PW-1] && !py[PW-1] && (px < GRID_LIM) && (py < GRID_LIM);

      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_addr    = clr_ff;
         mem_wr_data = 1'b0;
      end else if (state_ff == ST_IDLE) begin
         mem_wr_en   = accept && (req_bus.operation == OP_WRITE) &&
                       ((req_bus.cell_x >> GRID_BITS) == '0) &&
                       ((req_bus.cell_y >> GRID_BITS) == '0);
         mem_addr    = {wy, wx};
         mem_wr_data = req_bus.blocked;
      end else begin
         mem_wr_en   = 1'b0;
         mem_addr    = {py[GRID_BITS-1:0], px[GRID_BITS-1:0]};
         mem_wr_data = 1'b0;
      end
   end

   assign line_clear = !(hit_ff || (live_ff && mem_rd_data));

   // next values of control and walk registers
   always_comb begin
      logic [COORD_W-1:0] dx, dy;
      logic               px_up, py_up, nzx, nzy;
      px_up = req_bus.end_x > req_bus.start_x;
      py_up = req_bus.end_y > req_bus.start_y;
      dx    = px_up ? req_bus.end_x - req_bus.start_x : req_bus.start_x - req_bus.end_x;
      dy    = py_up ? req_bus.end_y - req_bus.start_y : req_bus.start_y - req_bus.end_y;
      nzx   = dx > COORD_W'(tol);
      nzy   = dy > COORD_W'(tol);

      clr_in  = (state_ff == ST_CLEAR) ? clr_ff + ADDR_W'(1) : clr_ff;
      k_in    = ((state_ff == ST_PT_START) || (state_ff == ST_PT_END)) ? k_ff + 2'd1 : 2'd0;
      live_in = probe_go;
      hit_in  = query_go ? 1'b0 : (hit_ff || (live_ff && mem_rd_data));

      x_in = x_ff;   y_in = y_ff;   ex_in = ex_ff; ey_in = ey_ff;
      sxn_in = sxn_ff; sxm_in = sxm_ff; syn_in = syn_ff; sym_in = sym_ff;
      hline_in = hline_ff; vline_in = vline_ff;
      lax_in = lax_ff; lay_in = lay_ff; lbx_in = lbx_ff; lby_in = lby_ff;
      gapx_in = gapx_ff; gapy_in = gapy_ff; adx_in = adx_ff; ady_in = ady_ff;

      if (query_go) begin
         x_in     = cell_of(req_bus.start_x);
         y_in     = cell_of(req_bus.start_y);
         ex_in    = cell_of(req_bus.end_x);
         ey_in    = cell_of(req_bus.end_y);
         sxn_in   = nzx;
         sxm_in   = !px_up;
         syn_in   = nzy;
         sym_in   = !py_up;
         lax_in   = on_line(req_bus.start_x, tol);
         lay_in   = on_line(req_bus.start_y, tol);
         lbx_in   = on_line(req_bus.end_x, tol);
         lby_in   = on_line(req_bus.end_y, tol);
         hline_in = !nzy && on_line(req_bus.start_y, tol);
         vline_in = !nzx && on_line(req_bus.start_x, tol);
         gapx_in  = nzx ? first_gap(req_bus.start_x, px_up) : '0;
         gapy_in  = nzy ? first_gap(req_bus.start_y, py_up) : '0;
         adx_in   = dx;
         ady_in   = dy;
      end else if (state_ff == ST_WALK) begin
         x_in = nxt_x;
         y_in = nxt_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         k_ff     <= 2'd0;
         hit_ff   <= 1'b0;
         live_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         k_ff     <= k_in;
         hit_ff   <= hit_in;
         live_ff  <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      sxn_ff   <= sxn_in;
      sxm_ff   <= sxm_in;
      syn_ff   <= syn_in;
      sym_ff   <= sym_in;
      hline_ff <= hline_in;
      vline_ff <= vline_in;
      lax_ff   <= lax_in;
      lay_ff   <= lay_in;
      lbx_ff   <= lbx_in;
      lby_ff   <= lby_in;
      gapx_ff  <= gapx_in;
      gapy_ff  <= gapy_in;
      adx_ff   <= adx_in;
      ady_ff   <= ady_in;
   end

   assign gap_x = gapx_ff;
   assign gap_y = gapy_ff;
   assign adx   = adx_ff;
   assign ady   = ady_ff;

endmodule

@@ rtl/core/supercover_line_of_sight.sv @@
// supercover_line_of_sight: top level; config register, response register,
// sequencer, crossing unit and obstacle bitmap. Uses slos_pkg and both channel interfaces.
//
//   channel   dir   handshake        word
//   req_bus   in    valid/ready      operation, cell_x, cell_y, blocked, start/end x, y
//   rsp_bus   out   valid/ready      line_clear, one per query
//   csr_*     in    csr_we           coord_tolerance
//
// A write is taken while idle. A query loads the crossing unit, probes the start-point
// cells, walks each cell stepped (probing both side cells at an exact corner crossing and
// the neighbour on each step along a grid line), then probes the end-point cells; a segment
// with no motion on either axis stops after the start-point cells. After reset the bitmap
// is swept clear with req ready low. The response register takes a new word in the cycle
// its waiting result is taken; a finished query holds in its last state until it is free.
`timescale 1ns / 1ps

module supercover_line_of_sight #(
   parameter int GRID_BITS = 6,
   parameter int FRAC_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   slos_req_if.sink                   req_bus,
   slos_rsp_if.source                 rsp_bus,
   input  logic                       csr_we,
   input  logic [slos_pkg::TOL_W-1:0] csr_wdata
);
   import slos_pkg::*;

   localparam int ADDR_W = 2 * GRID_BITS;
   localparam int N_W    = ((COORD_W > FRAC_BITS) ? COORD_W : FRAC_BITS) + 1;

   logic [TOL_W-1:0]  tol_ff, tol_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              line_clear_ff, line_clear_in;
   logic              rsp_free, done, line_clear;
   logic              mem_wr_en, mem_wr_data, mem_rd_data;
   logic [ADDR_W-1:0] mem_addr;
   cross_cmd_type     cross_cmd;
   cross_stat_type    cross_stat;
   logic [N_W-1:0]     gap_x, gap_y;
   logic [COORD_W-1:0] adx, ady;

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      tol_in        = csr_we ? csr_wdata : tol_ff;
      rsp_valid_in  = done ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      line_clear_in = done ? line_clear : line_clear_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_clear_ff <= line_clear_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.line_clear = line_clear_ff;

   slos_seq #(
      .GRID_BITS(GRID_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .tol        (tol_ff),
      .rsp_free   (rsp_free),
      .done       (done),
      .line_clear (line_clear),
      .mem_wr_en  (mem_wr_en),
      .mem_addr   (mem_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_data(mem_rd_data),
      .cross_cmd  (cross_cmd),
      .cross_stat (cross_stat),
      .gap_x      (gap_x),
      .gap_y      (gap_y),
      .adx        (adx),
      .ady        (ady)
   );

   slos_cross_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) u_cross (
      .clock(clock),
      .cmd  (cross_cmd),
      .gap_x(gap_x),
      .gap_y(gap_y),
      .adx  (adx),
      .ady  (ady),
      .stat (cross_stat)
   );

   slos_map_mem #(
      .GRID_BITS(GRID_BITS)
   ) u_map (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .addr   (mem_addr),
      .wr_data(mem_wr_data),
      .rd_data(mem_rd_data)
   );

endmodule

@@ test/tb_supercover_line_of_sight.sv @@
// tb_supercover_line_of_sight: self-checking bench for the supercover line-of-sight block.
// Needs slos_pkg, slos_req_if, slos_rsp_if and supercover_line_of_sight; a scoreboard
// class keeps its own bitmap and walks each segment to predict line_clear.
`timescale 1ns / 1ps

module tb_supercover_line_of_sight;

   import slos_pkg::*;

   localparam int GRID_BITS  = 6;
   localparam int FRAC_BITS  = 8;
   localparam int GRID       = 1 << GRID_BITS;
   localparam int UNIT       = 1 << FRAC_BITS;
   localparam int COORD_MAX  = (1 << COORD_W) - 1;
   localparam int WIN_LO     = 8 * UNIT;
   localparam int WIN_HI     = 24 * UNIT - 1;
   localparam int QUIET_MAX  = 20000;
   localparam int RSP_HOLD   = 1500;
   localparam int SETTLE     = 8;
   localparam int DRAIN_WAIT = 400;
   localparam int PHASE_LEN  = 140;

   typedef struct {
      logic               op;
      logic [CELLF_W-1:0] cx;
      logic [CELLF_W-1:0] cy;
      logic               blk;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [COORD_W-1:0] ex;
      logic [COORD_W-1:0] ey;
   } sight_word_type;

   class sight_scoreboard;
      bit       obstacle [0:GRID*GRID-1];
      bit [3:0] tolerance;
      bit       clear_due [$];
      bit       blocked_seen;
      int       failures;
      int       answers;

      function new();
         foreach (obstacle[i]) obstacle[i] = 0;
         tolerance = 0;
         failures  = 0;
         answers   = 0;
      endfunction

      function int unsigned pending();
         return clear_due.size();
      endfunction

      function bit on_grid_line(int unsigned v);
         int unsigned f, d;
         f = v % UNIT;
         d = f;
         if (UNIT - f < d) d = UNIT - f;
         return d <= tolerance;
      endfunction

      function int axis_step(int unsigned a, int unsigned b);
         int d, t;
         t = tolerance;
         d = int'(b) - int'(a);
         if (d > t) return 1;
         if (d < -t) return -1;
         return 0;
      endfunction

      function void probe(int x, int y);
         if (x < 0 || y < 0 || x >= GRID || y >= GRID) return;
         if (obstacle[y * GRID + x]) blocked_seen = 1;
      endfunction

      function void point_cells(int unsigned vx, int unsigned vy);
         int  x, y;
         bit  lx, ly;
         x  = vx / UNIT;
         y  = vy / UNIT;
         lx = on_grid_line(vx);
         ly = on_grid_line(vy);
         probe(x, y);
         if (lx) probe(x - 1, y);
         if (ly) probe(x, y - 1);
         if (lx && ly) probe(x - 1, y - 1);
      endfunction

      function longint unsigned first_gap(int unsigned v, int s);
         longint unsigned c;
         c = v / UNIT;
         if (s > 0) return (c + 1) * UNIT - v;
         return v - c * UNIT;
      endfunction

      function bit segment_clear(int unsigned ax, int unsigned ay,
                                 int unsigned bx, int unsigned by);
         int              dir_x, dir_y, x, y, tx, ty;
         longint unsigned adx, ady, nx, ny, lhs, rhs;
         bit              hline, vline, xa, ya, mx, my;
         blocked_seen = 0;
         dir_x = axis_step(ax, bx);
         dir_y = axis_step(ay, by);
         x  = ax / UNIT;
         y  = ay / UNIT;
         tx = bx / UNIT;
         ty = by / UNIT;
         adx = (bx > ax) ? bx - ax : ax - bx;
         ady = (by > ay) ? by - ay : ay - by;
         point_cells(ax, ay);
         if (dir_x == 0 && dir_y == 0) return !blocked_seen;
         hline = (dir_y == 0) && on_grid_line(ay);
         vline = (dir_x == 0) && on_grid_line(ax);
         nx = (dir_x != 0) ? first_gap(ax, dir_x) : 0;
         ny = (dir_y != 0) ? first_gap(ay, dir_y) : 0;
         forever begin
            xa = (dir_x != 0) && (x != tx);
            ya = (dir_y != 0) && (y != ty);
            if (!xa && !ya) break;
            mx = xa;
            my = ya;
            if (xa && ya) begin
               lhs = nx * ady;
               rhs = ny * adx;
               mx  = lhs <= rhs;
               my  = rhs <= lhs;
            end
            if (mx && my) begin
               probe(x + dir_x, y);
               probe(x, y + dir_y);
            end
            if (mx) begin
               x  += dir_x;
               nx += UNIT;
            end
            if (my) begin
               y  += dir_y;
               ny += UNIT;
            end
            probe(x, y);
            if (hline) probe(x, y - 1);
            if (vline) probe(x - 1, y);
         end
         point_cells(bx, by);
         return !blocked_seen;
      endfunction

      function void note_word(sight_word_type w);
         if (w.op == OP_WRITE)
            obstacle[{w.cy, w.cx}] = w.blk;
         else
            clear_due.insert(clear_due.size(), segment_clear(w.sx, w.sy, w.ex, w.ey));
      endfunction

      function void check_word(logic got);
         bit want;
         answers++;
         if (clear_due.size() == 0) begin
            if (failures < 10)
               $display("%0t: answer %0d line_clear=%b with no query outstanding",
                        $time, answers, got);
            failures++;
            return;
         end
         want = clear_due.pop_front();
         if (got !== want) begin
            if (failures < 10)
               $display("%0t: answer %0d line_clear expected %b got %b",
                        $time, answers, want, got);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [TOL_W-1:0] csr_wdata;

   slos_req_if req_bus ();
   slos_rsp_if rsp_bus ();

   supercover_line_of_sight #(
      .GRID_BITS(GRID_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   sight_scoreboard sight_sb;
   sight_word_type  cur_word;
   bit              send_steady;
   bit              rsp_steady;
   bit              rsp_hold_long;
   int              quiet_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int unsigned pick_gap(bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic int jitter(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(int v);
      if (v < 0) return '0;
      if (v > COORD_MAX) return COORD_W'(COORD_MAX);
      return COORD_W'(v);
   endfunction

   function automatic logic [COORD_W-1:0] line_coord(int tol);
      return clamp_coord(int'($urandom_range(0, GRID)) * UNIT + jitter(tol + 1));
   endfunction

   function automatic logic [COORD_W-1:0] any_coord(int tol);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4) return COORD_W'($urandom_range(0, COORD_MAX));
      if (r < 7) return line_coord(tol);
      return COORD_W'($urandom_range(WIN_LO, WIN_HI));
   endfunction

   function automatic sight_word_type noise_word();
      sight_word_type w;
      w.op  = OP_QUERY;
      w.cx  = CELLF_W'($urandom_range(0, GRID - 1));
      w.cy  = CELLF_W'($urandom_range(0, GRID - 1));
      w.blk = 1'($urandom_range(0, 1));
      w.sx  = COORD_W'($urandom_range(0, COORD_MAX));
      w.sy  = COORD_W'($urandom_range(0, COORD_MAX));
      w.ex  = COORD_W'($urandom_range(0, COORD_MAX));
      w.ey  = COORD_W'($urandom_range(0, COORD_MAX));
      return w;
   endfunction

   function automatic sight_word_type make_write();
      sight_word_type w;
      w = noise_word();
      w.op = OP_WRITE;
      if ($urandom_range(0, 9) < 6) begin
         w.cx = CELLF_W'($urandom_range(WIN_LO / UNIT, WIN_HI / UNIT));
         w.cy = CELLF_W'($urandom_range(WIN_LO / UNIT, WIN_HI / UNIT));
      end
      w.blk = ($urandom_range(0, 99) < 60);
      return w;
   endfunction

   function automatic sight_word_type make_query(int tol);
      sight_word_type w;
      int             n;
      w = noise_word();
      w.sx = any_coord(tol);
      w.sy = any_coord(tol);
      case ($urandom_range(0, 9))
         0: begin
            w.ex = COORD_W'($urandom_range(0, COORD_MAX));
            w.ey = COORD_W'($urandom_range(0, COORD_MAX));
         end
         1: begin
            w.ex = clamp_coord(int'(w.sx) + jitter(tol));
            w.ey = clamp_coord(int'(w.sy) + jitter(tol));
         end
         2: begin
            w.sy = line_coord(tol);
            w.ey = clamp_coord(int'(w.sy) + jitter(tol));
            w.ex = clamp_coord(int'(w.sx) + jitter(1500));
         end
         3: begin
            w.sx = line_coord(tol);
            w.ex = clamp_coord(int'(w.sx) + jitter(tol));
            w.ey = clamp_coord(int'(w.sy) + jitter(1500));
         end
         4: begin
            n = $urandom_range(1, 2048);
            w.ex = clamp_coord(int'(w.sx) + ($urandom_range(0, 1) ? n : -n));
            w.ey = clamp_coord(int'(w.sy) + ($urandom_range(0, 1) ? n : -n));
         end
         default: begin
            w.ex = clamp_coord(int'(w.sx) + jitter(3 * UNIT));
            w.ey = clamp_coord(int'(w.sy) + jitter(3 * UNIT));
         end
      endcase
      return w;
   endfunction

   task automatic send_word(sight_word_type w);
      @(negedge clock);
      cur_word          = w;
      req_bus.valid     = 1'b1;
      req_bus.operation = w.op;
      req_bus.cell_x    = w.cx;
      req_bus.cell_y    = w.cy;
      req_bus.blocked   = w.blk;
      req_bus.start_x   = w.sx;
      req_bus.start_y   = w.sy;
      req_bus.end_x     = w.ex;
      req_bus.end_y     = w.ey;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic req_pause(int unsigned n);
      if (n == 0) return;
      @(negedge clock);
      req_bus.valid = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic issue(sight_word_type w);
      send_word(w);
      req_pause(pick_gap(send_steady));
   endtask

   task automatic put_cell(int x, int y, bit b);
      sight_word_type w;
      w = noise_word();
      w.op  = OP_WRITE;
      w.cx  = CELLF_W'(x);
      w.cy  = CELLF_W'(y);
      w.blk = b;
      issue(w);
   endtask

   task automatic ask_sight(int ax, int ay, int bx, int by);
      sight_word_type w;
      w = noise_word();
      w.sx = COORD_W'(ax);
      w.sy = COORD_W'(ay);
      w.ex = COORD_W'(bx);
      w.ey = COORD_W'(by);
      issue(w);
   endtask

   task automatic set_tolerance(logic [TOL_W-1:0] v);
      req_pause(1);
      while (sight_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
      sight_sb.tolerance = v;
   endtask

   // response side: random back-pressure, plus one long hold on request
   initial begin
      int unsigned wait_left;
      rsp_bus.ready = 1'b0;
      wait_left     = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_long) begin
            rsp_hold_long = 1'b0;
            wait_left     = RSP_HOLD;
         end
         if (wait_left > 0) begin
            rsp_bus.ready = 1'b0;
            wait_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            wait_left     = pick_gap(rsp_steady);
         end
      end
   end

   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         sight_sb.check_word(rsp_bus.line_clear);
         moved = 1'b1;
      end
      if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         sight_sb.note_word(cur_word);
         moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [TOL_W-1:0] tol_plan [0:5];
      int               tol;
      sight_sb      = new();
      quiet_cycles  = 0;
      send_steady   = 1'b0;
      rsp_steady    = 1'b0;
      rsp_hold_long = 1'b0;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      cur_word      = noise_word();
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_WRITE;
      req_bus.cell_x    = '0;
      req_bus.cell_y    = '0;
      req_bus.blocked   = 1'b0;
      req_bus.start_x   = '0;
      req_bus.start_y   = '0;
      req_bus.end_x     = '0;
      req_bus.end_y     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: map corners, degenerate points, grid-line and corner walks
      set_tolerance(4'd0);
      put_cell(63, 63, 1'b1);
      put_cell(0, 0, 1'b1);
      ask_sight(0, 0, 0, 0);
      ask_sight(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      put_cell(0, 0, 1'b0);
      ask_sight(0, 0, COORD_MAX, COORD_MAX);
      put_cell(5, 4, 1'b1);
      ask_sight(2 * UNIT, 5 * UNIT, 10 * UNIT, 5 * UNIT);
      put_cell(6, 3, 1'b1);
      ask_sight(7 * UNIT, 9 * UNIT, 7 * UNIT, 1 * UNIT);
      put_cell(21, 20, 1'b1);
      ask_sight(20 * UNIT + 128, 20 * UNIT + 128, 22 * UNIT + 128, 22 * UNIT + 128);
      ask_sight(40 * UNIT + 128, 10 * UNIT + 128, 10 * UNIT + 77, 40 * UNIT + 200);
      ask_sight(30 * UNIT + 100, 50 * UNIT + 3, 33 * UNIT + 9, 50 * UNIT + 3);

      // tolerance > 0: near-line just below an integer, motion inside tolerance
      set_tolerance(4'd2);
      put_cell(28, 30, 1'b1);
      ask_sight(30 * UNIT - 1, 30 * UNIT + 100, 30 * UNIT - 1, 30 * UNIT + 100);
      ask_sight(30 * UNIT - 2, 30 * UNIT + 100, 30 * UNIT + 1, 30 * UNIT + 101);
      ask_sight(1000, 45 * UNIT + 10, 1002, 48 * UNIT + 10);
      ask_sight(COORD_MAX, 0, 0, COORD_MAX);
      put_cell(28, 30, 1'b0);
      ask_sight(28 * UNIT + 40, 29 * UNIT, 31 * UNIT + 40, 32 * UNIT);

      tol_plan[0] = 4'd15;
      tol_plan[1] = 4'd1;
      tol_plan[2] = 4'd0;
      tol_plan[3] = 4'd7;
      tol_plan[4] = 4'd3;
      tol_plan[5] = TOL_W'($urandom_range(0, 15));
      for (int p = 0; p < 6; p++) begin
         set_tolerance(tol_plan[p]);
         tol           = tol_plan[p];
         send_steady   = (p == 3);
         rsp_steady    = (p == 4);
         rsp_hold_long = (p == 1);
         for (int i = 0; i < PHASE_LEN; i++) begin
            if ($urandom_range(0, 3) == 0)
               issue(make_write());
            else
               issue(make_query(tol));
         end
      end

      req_pause(1);
      while (sight_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sight_sb.failures == 0 && sight_sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ supercover_line_of_sight.f @@
rtl/core/slos_pkg.sv
rtl/core/slos_req_if.sv
rtl/core/slos_rsp_if.sv
rtl/core/slos_map_mem.sv
rtl/core/slos_cross_unit.sv
rtl/core/slos_seq.sv
rtl/core/supercover_line_of_sight.sv
test/tb_supercover_line_of_sight.sv
